// File: hw/rtl/pixel_transfer_lut_remap_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel transfer remap block
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TRANSFER_LUT_REMAP_DEFINES_SVH
`define PIXEL_TRANSFER_LUT_REMAP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PXLUT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define PXLUT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pxlut_pkg.sv
// ----------------------------------------------------------------------------
// pxlut_pkg
// Codes, widths and types shared by the pixel transfer remap block.
// ----------------------------------------------------------------------------
package pxlut_pkg;

   // Item actions carried in req_tuser
   localparam logic [2:0] ACT_RED_WR   = 3'd0;
   localparam logic [2:0] ACT_GREEN_WR = 3'd1;
   localparam logic [2:0] ACT_BLUE_WR  = 3'd2;
   localparam logic [2:0] ACT_PAL_WR   = 3'd3;
   localparam logic [2:0] ACT_PIXEL    = 3'd4;

   // Source formats
   localparam logic [2:0] FMT_INVALID   = 3'd0;
   localparam logic [2:0] FMT_1BPP_RGB  = 3'd1;
   localparam logic [2:0] FMT_1BPP_MASK = 3'd2;
   localparam logic [2:0] FMT_8BPP_RGB  = 3'd3;
   localparam logic [2:0] FMT_8BPP_MASK = 3'd4;
   localparam logic [2:0] FMT_RGB       = 3'd5;
   localparam logic [2:0] FMT_RGB32     = 3'd6;
   localparam logic [2:0] FMT_ARGB      = 3'd7;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_FORMAT  = 2'd0;
   localparam logic [1:0] CSR_PAL_EN  = 2'd1;
   localparam logic [1:0] CSR_PAD     = 2'd2;

   // Channel widths
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 40;

   // Bit-plane limits and entries
   localparam logic [3:0] BITS_MAX   = 4'd8;
   localparam logic [7:0] ENTRY_ONE  = 8'd255;
   localparam logic [7:0] ENTRY_ZERO = 8'd0;

   // Valid byte counts of a result
   localparam logic [2:0] BYTES_MASK = 3'd1;
   localparam logic [2:0] BYTES_RGB  = 3'd3;
   localparam logic [2:0] BYTES_FOUR = 3'd4;

   // Result layout
   typedef enum logic [1:0] {
      KIND_MASK,
      KIND_RGB,
      KIND_ARGB
   } out_kind_type;

endpackage

// File: hw/rtl/pixel_transfer_lut_remap.sv
// ----------------------------------------------------------------------------
// pixel_transfer_lut_remap
// Per-channel table remap of source pixels, with optional palette stage.
//
//   channel | direction | contents
//   req     | in        | tuser: action; tdata: table_index, table_value,
//           |           |        source_pixel, bit_count
//   rsp     | out       | tdata: out_bytes, byte_count; tlast: last
//   csr     | in        | we, index, wdata (source_format, palette_enable,
//           |           |                   pad_to_four)
//
// One item per cycle unless a stalled output or a 1bpp run holds the lookup
// stage; a 1bpp byte yields bit_count results, one lookup-stage table read per
// result. Items register in the lookup stage, results in the output stage.
// Reset clears valid flags and csr registers and empties the pipeline; tables
// and palette are undefined until written. With rsp_tready low the output
// stage holds its result and the lookup stage can still take one more item.
// ----------------------------------------------------------------------------
`include "pixel_transfer_lut_remap_defines.svh"

module pixel_transfer_lut_remap (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] table_index, [39:8] table_value, [71:40] source_pixel,
   // [75:72] bit_count, [79:76] zero
   input  logic [pxlut_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] action
   input  logic [2:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] out_bytes, [34:32] byte_count, [39:35] zero
   output logic [pxlut_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [2:0]                       csr_wdata
);

   // Configuration registers
   logic [2:0] fmt_ff, fmt_in;
   logic       pal_en_ff, pal_en_in;
   logic       pad_ff, pad_in;

   // Input unpacking
   logic [7:0]  req_index;
   logic [31:0] req_value;
   logic [31:0] req_pixel;
   logic [3:0]  req_bits;
   logic [3:0]  req_bits_sat;
   logic        req_fire;

   // Palette memory and its read register
   logic [31:0] pal_mem [256];
   logic [31:0] pal_rd_ff;

   // Lookup stage
   logic        p2_valid_ff, p2_valid_in;
   logic [2:0]  p2_action_ff, p2_action_in;
   logic [7:0]  p2_index_ff, p2_index_in;
   logic [7:0]  p2_byte_ff, p2_byte_in;
   logic [31:0] p2_pixel_ff, p2_pixel_in;
   logic [7:0]  p2_shift_ff, p2_shift_in;
   logic [3:0]  p2_count_ff, p2_count_in;
   logic        p2_is_1bpp;
   logic        p2_has_result;
   logic        p2_step;
   logic        p2_leave;
   logic        p2_last;
   logic [7:0]  bit_entry;
   logic [7:0]  red_addr, green_addr, blue_addr;
   pxlut_pkg::out_kind_type p2_kind;
   logic [2:0]  p2_bytes;

   // Table memories and read registers
   logic [7:0] red_mem   [256];
   logic [7:0] green_mem [256];
   logic [7:0] blue_mem  [256];
   logic [7:0] red_rd_ff, green_rd_ff, blue_rd_ff;

   // Output stage
   logic                    p3_valid_ff, p3_valid_in;
   pxlut_pkg::out_kind_type p3_kind_ff;
   logic [7:0]              p3_alpha_ff;
   logic [2:0]              p3_bytes_ff;
   logic                    p3_last_ff;
   logic                    p3_free;
   logic [31:0]             out_bytes;

   // Decode the csr write
   always_comb begin
      fmt_in    = fmt_ff;
      pal_en_in = pal_en_ff;
      pad_in    = pad_ff;
      if (csr_we) begin
         case (csr_index)
            pxlut_pkg::CSR_FORMAT: fmt_in    = csr_wdata;
            pxlut_pkg::CSR_PAL_EN: pal_en_in = csr_wdata[0];
            pxlut_pkg::CSR_PAD:    pad_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= pxlut_pkg::FMT_INVALID;
         pal_en_ff <= 1'b0;
         pad_ff    <= 1'b0;
      end else begin
         fmt_ff    <= fmt_in;
         pal_en_ff <= pal_en_in;
         pad_ff    <= pad_in;
      end
   end

   // Unpack the item and clamp the bit count
   assign req_index    = req_tdata[7:0];
   assign req_value    = req_tdata[39:8];
   assign req_pixel    = req_tdata[71:40];
   assign req_bits     = req_tdata[75:72];
   assign req_bits_sat = (req_bits > pxlut_pkg::BITS_MAX) ? pxlut_pkg::BITS_MAX : req_bits;
   assign req_fire     = req_tvalid & req_tready;

   // Write or read the palette as the item is taken
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == pxlut_pkg::ACT_PAL_WR)) begin
         pal_mem[req_index] <= req_value;
      end
      if (req_fire) begin
         pal_rd_ff <= pal_mem[req_pixel[7:0]];
      end
   end

   // Classify the item in the lookup stage
   assign p2_is_1bpp = (fmt_ff == pxlut_pkg::FMT_1BPP_RGB) ||
                       (fmt_ff == pxlut_pkg::FMT_1BPP_MASK);
   assign p2_has_result = (p2_action_ff == pxlut_pkg::ACT_PIXEL) &&
                          (fmt_ff != pxlut_pkg::FMT_INVALID) &&
                          !(p2_is_1bpp && (p2_count_ff == 4'd0));
   assign p3_free  = !p3_valid_ff || rsp_tready;
   assign p2_step  = p2_valid_ff && (!p2_has_result || p3_free);
   assign p2_last  = !p2_is_1bpp || (p2_count_ff == 4'd1);
   assign p2_leave = p2_step && (!p2_has_result || p2_last);
   assign req_tready = !p2_valid_ff || p2_leave;

   // Advance the lookup stage: load, step through bits, or drain
   always_comb begin
      p2_valid_in  = p2_valid_ff;
      p2_action_in = p2_action_ff;
      p2_index_in  = p2_index_ff;
      p2_byte_in   = p2_byte_ff;
      p2_pixel_in  = p2_pixel_ff;
      p2_shift_in  = p2_shift_ff;
      p2_count_in  = p2_count_ff;
      if (req_fire) begin
         p2_valid_in  = 1'b1;
         p2_action_in = req_tuser;
         p2_index_in  = req_index;
         p2_byte_in   = req_value[7:0];
         p2_pixel_in  = req_pixel;
         p2_shift_in  = req_pixel[7:0];
         p2_count_in  = req_bits_sat;
      end else if (p2_leave) begin
         p2_valid_in = 1'b0;
      end else if (p2_step) begin
         p2_shift_in = {p2_shift_ff[6:0], 1'b0};
         p2_count_in = p2_count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p2_valid_in;
      end
      p2_action_ff <= p2_action_in;
      p2_index_ff  <= p2_index_in;
      p2_byte_ff   <= p2_byte_in;
      p2_pixel_ff  <= p2_pixel_in;
      p2_shift_ff  <= p2_shift_in;
      p2_count_ff  <= p2_count_in;
   end

   // Pick table addresses by source format
   assign bit_entry = p2_shift_ff[7] ? pxlut_pkg::ENTRY_ONE : pxlut_pkg::ENTRY_ZERO;

   always_comb begin
      red_addr   = p2_pixel_ff[7:0];
      green_addr = p2_pixel_ff[7:0];
      blue_addr  = p2_pixel_ff[7:0];
      case (fmt_ff)
         pxlut_pkg::FMT_1BPP_RGB, pxlut_pkg::FMT_1BPP_MASK: begin
            red_addr   = bit_entry;
            green_addr = bit_entry;
            blue_addr  = bit_entry;
         end
         pxlut_pkg::FMT_8BPP_RGB: begin
            if (pal_en_ff) begin
               red_addr   = pal_rd_ff[23:16];
               green_addr = pal_rd_ff[15:8];
               blue_addr  = pal_rd_ff[7:0];
            end
         end
         pxlut_pkg::FMT_RGB, pxlut_pkg::FMT_RGB32, pxlut_pkg::FMT_ARGB: begin
            red_addr   = p2_pixel_ff[23:16];
            green_addr = p2_pixel_ff[15:8];
            blue_addr  = p2_pixel_ff[7:0];
         end
         default: ;
      endcase
   end

   // Pick result layout and byte count
   always_comb begin
      case (fmt_ff)
         pxlut_pkg::FMT_1BPP_MASK, pxlut_pkg::FMT_8BPP_MASK: begin
            p2_kind  = pxlut_pkg::KIND_MASK;
            p2_bytes = pxlut_pkg::BYTES_MASK;
         end
         pxlut_pkg::FMT_ARGB: begin
            p2_kind  = pxlut_pkg::KIND_ARGB;
            p2_bytes = pxlut_pkg::BYTES_FOUR;
         end
         default: begin
            p2_kind  = pxlut_pkg::KIND_RGB;
            p2_bytes = pad_ff ? pxlut_pkg::BYTES_FOUR : pxlut_pkg::BYTES_RGB;
         end
      endcase
   end

   // Write or read the tables; both happen in this stage, so order is kept
   always_ff @(posedge clock) begin
      if (p2_step && (p2_action_ff == pxlut_pkg::ACT_RED_WR)) begin
         red_mem[p2_index_ff] <= p2_byte_ff;
      end
      if (p2_step && (p2_action_ff == pxlut_pkg::ACT_GREEN_WR)) begin
         green_mem[p2_index_ff] <= p2_byte_ff;
      end
      if (p2_step && (p2_action_ff == pxlut_pkg::ACT_BLUE_WR)) begin
         blue_mem[p2_index_ff] <= p2_byte_ff;
      end
      if (p2_step && p2_has_result) begin
         red_rd_ff   <= red_mem[red_addr];
         green_rd_ff <= green_mem[green_addr];
         blue_rd_ff  <= blue_mem[blue_addr];
      end
   end

   // Hold or advance the output stage
   always_comb begin
      p3_valid_in = p3_valid_ff;
      if (p2_step && p2_has_result) begin
         p3_valid_in = 1'b1;
      end else if (rsp_tready) begin
         p3_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p3_valid_in;
      end
      if (p2_step && p2_has_result) begin
         p3_kind_ff  <= p2_kind;
         p3_alpha_ff <= p2_pixel_ff[31:24];
         p3_bytes_ff <= p2_bytes;
         p3_last_ff  <= p2_last;
      end
   end

   // Pack the result bytes, blue lowest
   always_comb begin
      case (p3_kind_ff)
         pxlut_pkg::KIND_MASK: out_bytes = {24'd0, red_rd_ff};
         pxlut_pkg::KIND_ARGB: out_bytes = {p3_alpha_ff, red_rd_ff, green_rd_ff, blue_rd_ff};
         default:              out_bytes = {8'd0, red_rd_ff, green_rd_ff, blue_rd_ff};
      endcase
   end

   assign rsp_tvalid = p3_valid_ff;
   assign rsp_tdata  = {5'd0, p3_bytes_ff, out_bytes};
   assign rsp_tlast  = p3_last_ff;

   // A run that is not finished still has its source byte in the lookup stage
   `PXLUT_ASSERT_IMPLY(a_run_backed, clock, reset, rsp_tvalid && !rsp_tlast,
                       p2_valid_ff, "run result without pending source byte")
   // The next result of a run follows without a gap
   `PXLUT_ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
                      rsp_tvalid, "gap inside a run")
   // A lookup step that does not finish the item keeps it in place
   `PXLUT_ASSERT_NEXT(a_step_keeps, clock, reset, p2_step && !p2_leave,
                      p2_valid_ff, "item dropped mid run")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-channel table remap block. A directed table
// loads the lookup tables and palette and walks every source format; random
// phases then sweep the register settings under varied stream back-pressure.
// Every accepted item is run through a local remap predictor, and each result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   // Actions that the block ignores
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 21;
   localparam int N_PHASES     = 9;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One directed step: either an item or a register write
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]  action;
      logic [7:0]  index;      // table entry, or register index
      logic [31:0] value;      // table value, or register value
      logic [31:0] pixel;
      logic [3:0]  nbits;
      logic        typed;      // expected result given in the row
      logic [31:0] exp_bytes;
      logic [2:0]  exp_count;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] pixel_bytes;
      logic [2:0]  nbytes;
      logic        last;
   } pix_result_type;

   // Format under test per random phase
   localparam logic [2:0] PHASE_FMT [N_PHASES] = '{
      pxlut_pkg::FMT_RGB, pxlut_pkg::FMT_1BPP_RGB, pxlut_pkg::FMT_8BPP_RGB,
      pxlut_pkg::FMT_ARGB, pxlut_pkg::FMT_1BPP_MASK, pxlut_pkg::FMT_8BPP_RGB,
      pxlut_pkg::FMT_RGB32, pxlut_pkg::FMT_8BPP_MASK, pxlut_pkg::FMT_INVALID
   };

   localparam int N_DIRECTED = 36;
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // invalid format right after reset: no result
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h12345678, 4'd8, 1'b0, 32'h0, 3'd0},
      // load entries 0 and 255 of every table and palette entry 255, some with upper value bits set
      '{ROW_ITEM, pxlut_pkg::ACT_RED_WR, 8'h00, 32'hFFFFFF11,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_GREEN_WR, 8'h00, 32'h00000022,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_BLUE_WR, 8'h00, 32'hABCDEF33,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_RED_WR, 8'hFF, 32'h000000EE,
        32'h0, 4'd15, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_GREEN_WR, 8'hFF, 32'h123456DD,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_BLUE_WR, 8'hFF, 32'hFFFFFFCC,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PAL_WR, 8'hFF, 32'hA5FF00FF,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      // unused actions: ignored
      '{ROW_ITEM, ACT_UNUSED_LO, 8'hFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 4'd15, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, ACT_UNUSED_HI, 8'h00, 32'h0,
        32'h0, 4'd1, 1'b0, 32'h0, 3'd0},
      // 1bpp rgb: full byte, zero count, saturated count, single bit
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_1BPP_RGB),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h000000A5, 4'd8, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h000000FF, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'hFFFFFF3C, 4'd15, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h00000080, 4'd1, 1'b1, 32'h00EEDDCC, pxlut_pkg::BYTES_RGB},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAD), 32'd1,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h0000007F, 4'd1, 1'b1, 32'h00112233, pxlut_pkg::BYTES_FOUR},
      // 1bpp mask with pad set: pad has no effect
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_1BPP_MASK),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h00000080, 4'd2, 1'b0, 32'h0, 3'd0},
      // 8bpp through the palette, then direct
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_8BPP_RGB),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAL_EN), 32'd1,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'hFFFFFFFF, 4'd0, 1'b1, 32'h00EE22CC, pxlut_pkg::BYTES_FOUR},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAL_EN), 32'd0,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'hABCDEF00, 4'd0, 1'b1, 32'h00112233, pxlut_pkg::BYTES_FOUR},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_8BPP_MASK),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h123456FF, 4'd0, 1'b1, 32'h000000EE, pxlut_pkg::BYTES_MASK},
      // 24-bit and 32-bit sources: byte3 ignored
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_RGB),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAD), 32'd0,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'hFF00FF00, 4'd0, 1'b1, 32'h0011DD33, pxlut_pkg::BYTES_RGB},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_RGB32),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h00FF00FF, 4'd0, 1'b1, 32'h00EE22CC, pxlut_pkg::BYTES_RGB},
      // argb keeps alpha, pad has no effect
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_FORMAT), 32'(pxlut_pkg::FMT_ARGB),
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAD), 32'd1,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h7FFF00FF, 4'd0, 1'b1, 32'h7FEE22CC, pxlut_pkg::BYTES_FOUR},
      '{ROW_CSR, 3'd0, 8'(pxlut_pkg::CSR_PAD), 32'd0,
        32'h0, 4'd0, 1'b0, 32'h0, 3'd0},
      '{ROW_ITEM, pxlut_pkg::ACT_PIXEL, 8'h00, 32'h0,
        32'h80000000, 4'd0, 1'b1, 32'h80112233, pxlut_pkg::BYTES_FOUR}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [pxlut_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [2:0]                        req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pxlut_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_we = 1'b0;
   logic [1:0]                        csr_index = '0;
   logic [2:0]                        csr_wdata = '0;

   // Typed expectation travelling with the current item
   logic                   typed_row = 1'b0;
   logic [31:0]            typed_bytes = '0;
   logic [2:0]             typed_count = '0;

   // Predictor state: tables, palette and register shadows
   logic [7:0]  red_lut [256];
   logic [7:0]  green_lut [256];
   logic [7:0]  blue_lut [256];
   logic [31:0] palette_lut [256];
   logic [2:0]  fmt_reg = pxlut_pkg::FMT_INVALID;
   logic        pal_en_reg = 1'b0;
   logic        pad_reg = 1'b0;

   // Entries already sent, so no pixel reads an unwritten one
   bit          tbl_known [3][256];
   bit          pal_known [256];
   logic [31:0] pal_sent [256];

   pix_result_type expected_pixels [$];
   pix_result_type lut_out [8];
   int          lut_count;
   int          error_count = 0;
   int          items_sent = 0;

   idle_mode_type idle_mode = IDLE_NONE;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   pixel_transfer_lut_remap DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop for a hung run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [31:0] rgb_word(input logic [7:0] b_idx, input logic [7:0] g_idx,
                                           input logic [7:0] r_idx);
      return {8'h00, red_lut[r_idx], green_lut[g_idx], blue_lut[b_idx]};
   endfunction

   task automatic add_result(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last);
      lut_out[lut_count] = '{word, nbytes, last};
      lut_count++;
   endtask

   // Update table state or translate one pixel item into lut_out
   task automatic remap_item(input logic [2:0] act, input logic [7:0] idx,
                             input logic [31:0] val, input logic [31:0] px,
                             input logic [3:0] nb);
      logic [7:0]  e;
      logic [31:0] w;
      logic [2:0]  rgb_n;
      int          n;
      rgb_n = pad_reg ? pxlut_pkg::BYTES_FOUR : pxlut_pkg::BYTES_RGB;
      lut_count = 0;
      case (act)
         pxlut_pkg::ACT_RED_WR:   red_lut[idx] = val[7:0];
         pxlut_pkg::ACT_GREEN_WR: green_lut[idx] = val[7:0];
         pxlut_pkg::ACT_BLUE_WR:  blue_lut[idx] = val[7:0];
         pxlut_pkg::ACT_PAL_WR:   palette_lut[idx] = val;
         pxlut_pkg::ACT_PIXEL: begin
            case (fmt_reg)
               pxlut_pkg::FMT_1BPP_RGB, pxlut_pkg::FMT_1BPP_MASK: begin
                  // one result per bit, MSB first, count saturates
                  n = (nb > pxlut_pkg::BITS_MAX) ? int'(pxlut_pkg::BITS_MAX) : int'(nb);
                  for (int i = 0; i < n; i++) begin
                     e = px[7 - i] ? pxlut_pkg::ENTRY_ONE : pxlut_pkg::ENTRY_ZERO;
                     if (fmt_reg == pxlut_pkg::FMT_1BPP_RGB) begin
                        add_result(rgb_word(e, e, e), rgb_n, i == n - 1);
                     end else begin
                        add_result({24'h0, red_lut[e]}, pxlut_pkg::BYTES_MASK, i == n - 1);
                     end
                  end
               end
               pxlut_pkg::FMT_8BPP_RGB: begin
                  if (pal_en_reg) begin
                     w = palette_lut[px[7:0]];
                     add_result(rgb_word(w[7:0], w[15:8], w[23:16]), rgb_n, 1'b1);
                  end else begin
                     add_result(rgb_word(px[7:0], px[7:0], px[7:0]), rgb_n, 1'b1);
                  end
               end
               pxlut_pkg::FMT_8BPP_MASK: begin
                  add_result({24'h0, red_lut[px[7:0]]}, pxlut_pkg::BYTES_MASK, 1'b1);
               end
               pxlut_pkg::FMT_RGB, pxlut_pkg::FMT_RGB32: begin
                  add_result(rgb_word(px[7:0], px[15:8], px[23:16]), rgb_n, 1'b1);
               end
               pxlut_pkg::FMT_ARGB: begin
                  add_result(rgb_word(px[7:0], px[15:8], px[23:16]) | {px[31:24], 24'h0},
                             pxlut_pkg::BYTES_FOUR, 1'b1);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   // Predict on every accepted item
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         remap_item(req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[71:40],
                    req_tdata[75:72]);
         if (typed_row) begin
            expected_pixels.push_back('{typed_bytes, typed_count, 1'b1});
         end else begin
            for (int i = 0; i < lut_count; i++) expected_pixels.push_back(lut_out[i]);
         end
      end
   end

   // Check every accepted result against the oldest prediction
   always @(posedge clock) begin
      pix_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[31:0] !== want.pixel_bytes)
               report_mismatch("out_bytes", rsp_tdata[31:0], want.pixel_bytes);
            if (rsp_tdata[34:32] !== want.nbytes)
               report_mismatch("byte_count", 32'(rsp_tdata[34:32]), 32'(want.nbytes));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // Result side: random stalls per idle mode, plus requested long holds
   always @(negedge clock) begin
      int stall_pct;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      case (idle_mode)
         IDLE_RECV: stall_pct = 51;
         IDLE_BOTH: stall_pct = 33;
         default:   stall_pct = 0;
      endcase
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offer one item, with optional idle gaps; returns at a falling edge
   task automatic send_item(input logic [2:0] act, input logic [7:0] idx,
                            input logic [31:0] val, input logic [31:0] px,
                            input logic [3:0] nb, input logic typed,
                            input logic [31:0] exp_bytes, input logic [2:0] exp_count);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 33 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      if (act <= pxlut_pkg::ACT_BLUE_WR) tbl_known[act[1:0]][idx] = 1'b1;
      if (act == pxlut_pkg::ACT_PAL_WR) begin
         pal_known[idx] = 1'b1;
         pal_sent[idx] = val;
      end
      req_tvalid  <= 1'b1;
      req_tuser   <= act;
      req_tdata   <= {4'h0, nb, px, val, idx};
      typed_row   <= typed;
      typed_bytes <= exp_bytes;
      typed_count <= exp_count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Write a table entry first if it was never loaded
   task automatic ensure_table(input logic [2:0] act, input logic [7:0] idx);
      if (!tbl_known[act[1:0]][idx])
         send_item(act, idx, $urandom, $urandom, 4'($urandom), 1'b0, '0, '0);
   endtask

   // Load every entry that a pixel item will read under the current setting
   task automatic prime_pixel(input logic [31:0] px);
      logic [31:0] w;
      case (fmt_reg)
         pxlut_pkg::FMT_1BPP_RGB, pxlut_pkg::FMT_1BPP_MASK: begin
            for (int t = pxlut_pkg::ACT_RED_WR; t <= pxlut_pkg::ACT_BLUE_WR; t++) begin
               ensure_table(3'(t), pxlut_pkg::ENTRY_ZERO);
               ensure_table(3'(t), pxlut_pkg::ENTRY_ONE);
            end
         end
         pxlut_pkg::FMT_8BPP_RGB: begin
            if (pal_en_reg) begin
               if (!pal_known[px[7:0]])
                  send_item(pxlut_pkg::ACT_PAL_WR, px[7:0], $urandom, $urandom,
                            4'($urandom), 1'b0, '0, '0);
               w = pal_sent[px[7:0]];
               ensure_table(pxlut_pkg::ACT_BLUE_WR, w[7:0]);
               ensure_table(pxlut_pkg::ACT_GREEN_WR, w[15:8]);
               ensure_table(pxlut_pkg::ACT_RED_WR, w[23:16]);
            end else begin
               ensure_table(pxlut_pkg::ACT_BLUE_WR, px[7:0]);
               ensure_table(pxlut_pkg::ACT_GREEN_WR, px[7:0]);
               ensure_table(pxlut_pkg::ACT_RED_WR, px[7:0]);
            end
         end
         pxlut_pkg::FMT_8BPP_MASK: ensure_table(pxlut_pkg::ACT_RED_WR, px[7:0]);
         pxlut_pkg::FMT_RGB, pxlut_pkg::FMT_RGB32, pxlut_pkg::FMT_ARGB: begin
            ensure_table(pxlut_pkg::ACT_BLUE_WR, px[7:0]);
            ensure_table(pxlut_pkg::ACT_GREEN_WR, px[15:8]);
            ensure_table(pxlut_pkg::ACT_RED_WR, px[23:16]);
         end
         default: ;
      endcase
   endtask

   // Drop valid and wait until the block has nothing left in flight
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] which, input logic [2:0] val);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= val;
      case (which)
         pxlut_pkg::CSR_FORMAT: fmt_reg = val;
         pxlut_pkg::CSR_PAL_EN: pal_en_reg = val[0];
         pxlut_pkg::CSR_PAD:    pad_reg = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Main stimulus
   initial begin
      stim_row_type row;
      logic [31:0] px;
      logic [3:0]  nb;
      int          pick;
      int          phase_end;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_CSR) begin
            write_csr(row.index[1:0], row.value[2:0]);
         end else begin
            send_item(row.action, row.index, row.value, row.pixel, row.nbits, row.typed,
                      row.exp_bytes, row.exp_count);
         end
      end

      // Random phases over formats, palette, pad and idle modes
      for (int p = 0; p < N_PHASES; p++) begin
         write_csr(pxlut_pkg::CSR_FORMAT, PHASE_FMT[p]);
         write_csr(pxlut_pkg::CSR_PAL_EN, p[0] ? 3'd1 : 3'd0);
         write_csr(pxlut_pkg::CSR_PAD, p[1] ? 3'd1 : 3'd0);
         idle_mode = idle_mode_type'(p % 4);
         // hold the result side long enough to back up the input
         if (p == 4) hold_requests++;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               send_item(3'($urandom_range(pxlut_pkg::ACT_RED_WR, pxlut_pkg::ACT_BLUE_WR)),
                         8'($urandom), $urandom, $urandom, 4'($urandom), 1'b0, '0, '0);
            end else if (pick < 22) begin
               send_item(pxlut_pkg::ACT_PAL_WR, 8'($urandom), $urandom, $urandom,
                         4'($urandom), 1'b0, '0, '0);
            end else if (pick < 27) begin
               send_item(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), 8'($urandom),
                         $urandom, $urandom, 4'($urandom), 1'b0, '0, '0);
            end else begin
               px = $urandom;
               nb = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(1, 8))
                                                 : 4'($urandom_range(0, 15));
               prime_pixel(px);
               send_item(pxlut_pkg::ACT_PIXEL, 8'($urandom), $urandom, px, nb,
                         1'b0, '0, '0);
            end
         end
      end

      settle_block();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
